// ----- rtl/core/first_fit_slot_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// first_fit_slot_allocator_macros
// Assertion helpers shared by the allocator modules.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_SLOT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_SLOT_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FFSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffsa assertion failed");

// next-cycle implication
`define FFSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffsa assertion failed");

`endif

// ----- rtl/core/ffsa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared constants and types of the first-fit slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffsa_pkg;

  localparam int MAX_SLOTS_DEF = 16;

  localparam int WEIGHT_W = 10;
  localparam int SLOT_W   = 5;
  localparam int STATUS_W = 2;

  // request kinds
  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_PLACED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SKIPPED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 2'd3;

  // configuration register indexes
  localparam logic CFG_NUM_SLOTS     = 1'b0;
  localparam logic CFG_SLOT_CAPACITY = 1'b1;

  localparam logic [SLOT_W-1:0]   NUM_SLOTS_RST     = 5'd16;
  localparam logic [WEIGHT_W-1:0] SLOT_CAPACITY_RST = 10'd18;

  typedef struct packed {
    logic we;
    logic clear;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/ffsa_usage_mem.sv -----
// ----------------------------------------------------------------------------
// ffsa_usage_mem
// Slot usage memory: one write, one registered read, per-entry valid bits
// cleared at once by reset or a clear request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_slot_allocator_macros.svh"

module ffsa_usage_mem #(
  parameter int MAX_SLOTS = ffsa_pkg::MAX_SLOTS_DEF,
  parameter int AW        = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
  input  wire                             clk,
  input  wire                             rst,
  input  ffsa_pkg::mem_ctl_t              ctl,
  input  wire  [AW-1:0]                   raddr,
  input  wire  [AW-1:0]                   waddr,
  input  wire  [ffsa_pkg::WEIGHT_W-1:0]   wdata,
  output logic [ffsa_pkg::WEIGHT_W-1:0]   rdata
);

  logic [ffsa_pkg::WEIGHT_W-1:0] mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0]          valid;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    rdata <= valid[raddr] ? mem[raddr] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= '0;
    end else if (ctl.we) begin
      valid[waddr] <= 1'b1;
    end
  end

  `FFSA_ASSERT_NOW(a_we_clear_excl, ctl.we, !ctl.clear)
  `FFSA_ASSERT_NEXT(a_clear_empties, ctl.clear, valid == '0)
  `FFSA_ASSERT_NEXT(a_write_marks, ctl.we, valid[$past(waddr)])

endmodule

`default_nettype wire

// ----- rtl/core/ffsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Search sequencer: walks slots from the start slot, one usage read per
// cycle, writes the chosen slot back and keeps the plan state.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_slot_allocator_macros.svh"

module ffsa_ctrl #(
  parameter int MAX_SLOTS = ffsa_pkg::MAX_SLOTS_DEF,
  parameter int AW        = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire                             op,
  input  wire  [ffsa_pkg::WEIGHT_W-1:0]   item_weight,
  input  wire  [ffsa_pkg::SLOT_W-1:0]     earliest_slot,
  input  wire  [ffsa_pkg::SLOT_W-1:0]     num_slots,
  input  wire  [ffsa_pkg::WEIGHT_W-1:0]   slot_capacity,
  output ffsa_pkg::mem_ctl_t              mem_ctl,
  output logic [AW-1:0]                   raddr,
  output logic [AW-1:0]                   waddr,
  output logic [ffsa_pkg::WEIGHT_W-1:0]   wdata,
  input  wire  [ffsa_pkg::WEIGHT_W-1:0]   rdata,
  output logic                            res_valid,
  input  wire                             res_ready,
  output logic [ffsa_pkg::SLOT_W-1:0]     res_slot,
  output logic [ffsa_pkg::STATUS_W-1:0]   res_status
);

  localparam int CWR = $clog2(MAX_SLOTS + 2);
  localparam int CW  = (CWR > ffsa_pkg::SLOT_W) ? CWR : ffsa_pkg::SLOT_W;
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] MAXS = CW'(MAX_SLOTS);

  typedef enum logic [1:0] {IDLE, SEARCH, RESULT} state_t;

  state_t                        state;
  logic [CW-1:0]                 t;
  logic [CW-1:0]                 current_slot;
  logic                          failed;
  logic [ffsa_pkg::WEIGHT_W-1:0] weight;

  logic [CW-1:0]                 ns_ext;
  logic [CW-1:0]                 total;
  logic [CW-1:0]                 lo;
  logic [CW-1:0]                 t0;
  logic [CW-1:0]                 t0_m1;
  logic [CW-1:0]                 t_m1;
  logic [CW-1:0]                 t_inc;
  logic [ffsa_pkg::WEIGHT_W:0]   sum;
  logic                          fits;
  logic                          accept;

  always_comb begin
    ns_ext = CW'(num_slots);
    if (ns_ext == '0) begin
      total = ONE;
    end else if (ns_ext > MAXS) begin
      total = MAXS;
    end else begin
      total = ns_ext;
    end
    lo     = (earliest_slot == '0) ? ONE : CW'(earliest_slot);
    t0     = (lo < current_slot) ? current_slot : lo;
    t0_m1  = t0 - ONE;
    t_m1   = t - ONE;
    t_inc  = t + ONE;
    sum    = {1'b0, rdata} + {1'b0, weight};
    fits   = (sum <= {1'b0, slot_capacity});
    accept = in_valid && in_ready;
  end

  assign in_ready      = (state == IDLE);
  assign res_valid     = (state == RESULT);
  assign raddr         = (state == IDLE) ? t0_m1[AW-1:0] : t[AW-1:0];
  assign waddr         = t_m1[AW-1:0];
  assign wdata         = sum[ffsa_pkg::WEIGHT_W-1:0];
  assign mem_ctl.we    = (state == SEARCH) && fits;
  assign mem_ctl.clear = accept && (op == ffsa_pkg::OP_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      current_slot <= ONE;
      failed       <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (accept) begin
            weight <= item_weight;
            t      <= t0;
            priority if (op == ffsa_pkg::OP_CLEAR) begin
              current_slot <= ONE;
              failed       <= 1'b0;
              res_slot     <= '0;
              res_status   <= ffsa_pkg::ST_CLEARED;
              state        <= RESULT;
            end else if (failed) begin
              res_slot   <= '0;
              res_status <= ffsa_pkg::ST_SKIPPED;
              state      <= RESULT;
            end else if (t0 > total) begin
              failed     <= 1'b1;
              res_slot   <= '0;
              res_status <= ffsa_pkg::ST_NO_FIT;
              state      <= RESULT;
            end else begin
              state <= SEARCH;
            end
          end
        end
        SEARCH: begin
          if (fits) begin
            current_slot <= (sum >= {1'b0, slot_capacity}) ? t_inc : t;
            res_slot     <= t[ffsa_pkg::SLOT_W-1:0];
            res_status   <= ffsa_pkg::ST_PLACED;
            state        <= RESULT;
          end else if (t_inc > total) begin
            failed     <= 1'b1;
            res_slot   <= '0;
            res_status <= ffsa_pkg::ST_NO_FIT;
            state      <= RESULT;
          end else begin
            t <= t_inc;
          end
        end
        RESULT: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `FFSA_ASSERT_NOW(a_no_write_failed, failed, !mem_ctl.we)
  `FFSA_ASSERT_NOW(a_cur_range, 1'b1, current_slot >= ONE && current_slot <= MAXS + ONE)
  `FFSA_ASSERT_NEXT(a_write_gives_placed, mem_ctl.we,
                    state == RESULT && res_status == ffsa_pkg::ST_PLACED)

endmodule

`default_nettype wire

// ----- rtl/core/first_fit_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_slot_allocator
// First-fit placement of weighted items into capacity-limited slots.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_tvalid/s_tready: s_tuser is the op (place or clear),
//   s_tdata carries the item weight and earliest slot. One result per
//   request leaves on m_tvalid/m_tready: m_tdata is the assigned slot,
//   m_tuser the status.
//   A clear, a skipped request or an out-of-range start goes from acceptance
//   straight to the result state; a place request first searches the slots,
//   inspecting at most the slot count of them, the search walking the
//   usage memory at one read per cycle. Requests are handled one at a time.
//   The result sits in an output register, so the next request is taken
//   while it waits; a stalled receiver holds it and stops the sequencer at
//   its next result. Reset empties all slots at once, sets the start slot to
//   1, clears the failed flag and loads the register defaults (16 slots,
//   capacity 18). cfg_wen writes cfg_wdata to register cfg_index (0 slot count,
//   1 capacity); the user writes only while idle, the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_slot_allocator #(
  parameter int MAX_SLOTS = ffsa_pkg::MAX_SLOTS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // [9:0] item_weight, [14:10] earliest_slot
  input  wire         s_tuser,   // [0] op
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata,   // [4:0] assigned_slot
  output logic [1:0]  m_tuser,   // [1:0] status
  input  wire         cfg_wen,
  input  wire         cfg_index,
  input  wire  [9:0]  cfg_wdata
);

  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic [ffsa_pkg::SLOT_W-1:0]   num_slots;
  logic [ffsa_pkg::WEIGHT_W-1:0] slot_capacity;

  ffsa_pkg::mem_ctl_t            mem_ctl;
  logic [AW-1:0]                 raddr;
  logic [AW-1:0]                 waddr;
  logic [ffsa_pkg::WEIGHT_W-1:0] wdata;
  logic [ffsa_pkg::WEIGHT_W-1:0] rdata;
  logic                          res_valid;
  logic                          res_ready;
  logic [ffsa_pkg::SLOT_W-1:0]   res_slot;
  logic [ffsa_pkg::STATUS_W-1:0] res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_slots     <= ffsa_pkg::NUM_SLOTS_RST;
      slot_capacity <= ffsa_pkg::SLOT_CAPACITY_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        ffsa_pkg::CFG_NUM_SLOTS:     num_slots     <= cfg_wdata[ffsa_pkg::SLOT_W-1:0];
        ffsa_pkg::CFG_SLOT_CAPACITY: slot_capacity <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {3'b000, res_slot};
      m_tuser <= res_status;
    end
  end

  ffsa_ctrl #(
    .MAX_SLOTS (MAX_SLOTS),
    .AW        (AW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .op            (s_tuser),
    .item_weight   (s_tdata[9:0]),
    .earliest_slot (s_tdata[14:10]),
    .num_slots     (num_slots),
    .slot_capacity (slot_capacity),
    .mem_ctl       (mem_ctl),
    .raddr         (raddr),
    .waddr         (waddr),
    .wdata         (wdata),
    .rdata         (rdata),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_slot      (res_slot),
    .res_status    (res_status)
  );

  ffsa_usage_mem #(
    .MAX_SLOTS (MAX_SLOTS),
    .AW        (AW)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mem_ctl),
    .raddr (raddr),
    .waddr (waddr),
    .wdata (wdata),
    .rdata (rdata)
  );

endmodule

`default_nettype wire
